>>> rtl/substring_search_case_fold_top_assert.svh
// Assertion macros for the substring search RTL
`ifndef SUBSTRING_SEARCH_CASE_FOLD_TOP_ASSERT_SVH
`define SUBSTRING_SEARCH_CASE_FOLD_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define SSCF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every clock edge, reset included
`define SSCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSCF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSCF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/sscf_pkg.sv
// Shared types, constants and byte compare functions for the substring search block
package sscf_pkg;

  localparam int MAX_NEEDLE_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int OFFSET_W       = 16;
  localparam int NEEDLE_LEN_W   = 5;
  localparam int CFG_ADDR_W     = 2;
  localparam int CFG_DATA_W     = 64;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT      = 8'h20;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NEEDLE_LO = 2'd0,
    CFG_NEEDLE_HI = 2'd1,
    CFG_NEEDLE_LEN = 2'd2,
    CFG_FOLD_CASE = 2'd3
  } cfg_reg_t;

  // compare setup handed to one window cell
  typedef struct packed {
    logic       active;
    logic       fold;
    logic [7:0] needle_byte;
  } cell_cmp_t;

  function automatic logic [7:0] fold_byte(logic [7:0] c);
    logic [7:0] res;
    res = c;
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      res = c | CASE_BIT;
    end
    return res;
  endfunction

  function automatic logic byte_match(logic [7:0] a, logic [7:0] b, logic fold);
    logic res;
    if (fold) begin
      res = (fold_byte(a) == fold_byte(b));
    end else begin
      res = (a == b);
    end
    return res;
  endfunction

endpackage

>>> rtl/sscf_cell.sv
// One window cell: holds a past text byte, passes it on and compares it with its needle byte
module sscf_cell (
  input  logic                clk,
  input  logic                shift_en,
  input  logic [7:0]          byte_in,
  input  sscf_pkg::cell_cmp_t cmp,
  output logic [7:0]          byte_out,
  output logic                hit
);

  logic [7:0] byte_r;

  // advance the window by one byte on every accepted word
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  // an idle cell never blocks a match
  assign hit = !cmp.active || sscf_pkg::byte_match(byte_r, cmp.needle_byte, cmp.fold);

endmodule

>>> rtl/substring_search_case_fold_top.sv
// Top level of the streaming first-occurrence substring search with optional case folding
// Takes one haystack byte per clock and reports, once per text, whether the configured needle
// (1 to MAX_NEEDLE bytes) occurred and where its first occurrence starts. The incoming byte and
// a row of MAX_NEEDLE-1 window cells, each holding one earlier byte, are compared against the
// needle in the same cycle, so words are accepted back to back at one per clock. The result word
// is registered and appears on the output in the cycle after the acceptance of the byte marked
// with tlast. Non-final bytes are taken even while a result waits; a final byte waits only while
// the previous result is still unclaimed. In case-fold mode A to Z on both sides are folded to
// lower case before comparing. The byte count saturates at 2^COUNT_BITS-1 and the reported
// offset holds its low 16 bits. Write the configuration only while the block is idle.
`include "substring_search_case_fold_top_assert.svh"

module substring_search_case_fold_top #(
  parameter int MAX_NEEDLE = sscf_pkg::MAX_NEEDLE_DEF,
  parameter int COUNT_BITS = sscf_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] text_byte
  input  logic                                in_tlast,   // end_of_text
  // result words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,  // [0] match_found, [16:1] match_offset
  // configuration writes
  input  logic                                cfg_we,
  input  logic [sscf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sscf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int WIN   = MAX_NEEDLE - 1;
  localparam int IDX_W = $clog2(MAX_NEEDLE);
  localparam int LW    = sscf_pkg::NEEDLE_LEN_W;
  localparam int OW    = sscf_pkg::OFFSET_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]    needle_r [MAX_NEEDLE];
  logic [LW-1:0] len_r;      // needle length, already clamped to 1..MAX_NEEDLE
  logic          fold_r;
  logic [LW-1:0] len_wr;

  // needle bytes beyond MAX_NEEDLE are simply not stored
  for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_needle
    localparam sscf_pkg::cfg_reg_t SEL =
      (i < 8) ? sscf_pkg::CFG_NEEDLE_LO : sscf_pkg::CFG_NEEDLE_HI;
    localparam int LANE = i % 8;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        needle_r[i] <= '0;
      end else if (cfg_we && cfg_addr == SEL) begin
        needle_r[i] <= cfg_wdata[8*LANE +: 8];
      end
    end
  end

  // clamp the length once at write time: zero reads as one, too long reads as MAX_NEEDLE
  always_comb begin
    len_wr = cfg_wdata[LW-1:0];
    if (len_wr == '0) begin
      len_wr = LW'(1);
    end else if (len_wr > LW'(MAX_NEEDLE)) begin
      len_wr = LW'(MAX_NEEDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LW'(1);
      fold_r <= 1'b0;
    end else if (cfg_we) begin
      case (sscf_pkg::cfg_reg_t'(cfg_addr))
        sscf_pkg::CFG_NEEDLE_LEN: len_r  <= len_wr;
        sscf_pkg::CFG_FOLD_CASE:  fold_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic out_valid_r;

  // only a final byte needs the result slot; all other bytes flow freely
  assign in_tready = !out_valid_r || out_tready || !in_tlast;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Window: the incoming byte faces the last needle byte, cell k faces byte len-2-k
  // ---------------------------------------------------------------------------
  logic [LW-1:0]    len_m1;
  logic [IDX_W-1:0] cur_idx;
  logic             cur_hit;
  logic [7:0]       chain [WIN];
  logic [WIN-1:0]   cell_hits;

  assign len_m1  = len_r - LW'(1);
  assign cur_idx = len_m1[IDX_W-1:0];
  assign cur_hit = sscf_pkg::byte_match(in_tdata, needle_r[cur_idx], fold_r);

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    sscf_pkg::cell_cmp_t cmp;
    logic [LW-1:0]       idx_full;
    logic [7:0]          link_in;

    assign idx_full        = len_r - LW'(k + 2);
    assign cmp.active      = (len_r >= LW'(k + 2));
    assign cmp.fold        = fold_r;
    assign cmp.needle_byte = cmp.active ? needle_r[idx_full[IDX_W-1:0]] : 8'h00;

    if (k == 0) begin : g_head
      assign link_in = in_tdata;
    end else begin : g_link
      assign link_in = chain[k-1];
    end

    sscf_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .byte_in  (link_in),
      .cmp      (cmp),
      .byte_out (chain[k]),
      .hit      (cell_hits[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Stream state: count, first match
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] seen_r, seen_nxt;
  logic                  have_r, have_nxt;
  logic [OW-1:0]         first_off_r, first_off_nxt;
  logic [COUNT_BITS-1:0] start_pos;
  logic [OW-1:0]         offset_now;
  logic                  hit_now;

  // a match can only end once len bytes have been seen, and only the first one counts
  assign hit_now    = !have_r && (seen_r >= COUNT_BITS'(len_m1)) && cur_hit && (&cell_hits);
  assign start_pos  = seen_r - COUNT_BITS'(len_m1);
  assign offset_now = OW'(start_pos);

  always_comb begin
    seen_nxt      = seen_r;
    have_nxt      = have_r;
    first_off_nxt = first_off_r;
    if (in_acc) begin
      if (hit_now) begin
        have_nxt      = 1'b1;
        first_off_nxt = offset_now;
      end
      // hold the count at its maximum
      if (seen_r != '1) begin
        seen_nxt = seen_r + COUNT_BITS'(1);
      end
      // drop all stream state after the final byte
      if (in_tlast) begin
        seen_nxt      = '0;
        have_nxt      = 1'b0;
        first_off_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      have_r      <= 1'b0;
      first_off_r <= '0;
    end else begin
      seen_r      <= seen_nxt;
      have_r      <= have_nxt;
      first_off_r <= first_off_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic          out_valid_nxt;
  logic          found_r, found_nxt;
  logic [OW-1:0] out_off_r, out_off_nxt;
  logic          load_result;

  assign load_result = in_acc && in_tlast;

  always_comb begin
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    out_off_nxt   = out_off_r;
    if (load_result) begin
      out_valid_nxt = 1'b1;
      found_nxt     = have_r || hit_now;
      // first_off_r is zero while nothing has matched
      out_off_nxt   = hit_now ? offset_now : first_off_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r   <= found_nxt;
    out_off_r <= out_off_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_off_r, found_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SSCF_ASSERT_ALWAYS(a_reset_no_result, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  `SSCF_ASSERT(a_last_needs_slot, clk, rst_n, load_result |-> (!out_valid_r || out_tready), "final byte overwrote a pending result")
  `SSCF_ASSERT(a_result_from_last, clk, rst_n, $rose(out_tvalid) |-> $past(load_result), "result without a final byte")
  `SSCF_ASSERT(a_clear_after_last, clk, rst_n, load_result |=> (seen_r == '0 && !have_r && first_off_r == '0), "stream state not cleared after final byte")
  `SSCF_ASSERT(a_first_match_held, clk, rst_n, (have_r && !load_result) |=> (have_r && $stable(first_off_r)), "first match changed mid-stream")

endmodule
